/* design/tcpsd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpsd_pkg
// shared types and constants of the two-class priority server dispatcher
// ----------------------------------------------------------------------------
package tcpsd_pkg;

    localparam int TICK_W = 16;
    localparam int ID_W   = 16;
    localparam int SUM_W  = 32;

    localparam logic [ID_W-1:0]   LANDING_ID_FIRST = 16'd5001;
    localparam logic [ID_W-1:0]   TAKEOFF_ID_FIRST = 16'd1;
    localparam logic [TICK_W-1:0] TICK_FIRST       = 16'd1;

    // result kinds
    localparam logic [1:0] EV_LANDING = 2'd0;
    localparam logic [1:0] EV_TAKEOFF = 2'd1;
    localparam logic [1:0] EV_FREED   = 2'd2;
    localparam logic [1:0] EV_TICK    = 2'd3;

    // register indexes
    localparam logic [1:0] CFG_SERVER_COUNT = 2'd0;
    localparam logic [1:0] CFG_LANDING_TIME = 2'd1;
    localparam logic [1:0] CFG_TAKEOFF_TIME = 2'd2;

    typedef struct packed {
        logic [7:0]  remaining;
        logic [15:0] busy;
    } srv_entry_t;

endpackage

/* design/tcpsd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpsd_queue
// fifo of arrival ticks in a synchronous memory, with a registered head read
// ----------------------------------------------------------------------------
module tcpsd_queue #(
    parameter int DEPTH = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [tcpsd_pkg::TICK_W-1:0] push_data,
    input  logic                         pop,
    input  logic                         rd_en,
    output logic [tcpsd_pkg::TICK_W-1:0] rd_data,
    output logic [$clog2(DEPTH+1)-1:0]   count,
    output logic                         full
);
    import tcpsd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [TICK_W-1:0] mem [DEPTH];
    logic [TICK_W-1:0] rd_data_reg;
    logic [AW-1:0]     head_reg;
    logic [AW-1:0]     head_next;
    logic [CW-1:0]     count_reg;
    logic [AW:0]       tail_sum;
    logic [AW-1:0]     tail;

    assign tail_sum  = (AW+1)'(head_reg) + (AW+1)'(count_reg);
    assign tail      = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                                    : AW'(tail_sum);
    assign head_next = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign full      = (count_reg == CW'(DEPTH));
    assign count     = count_reg;
    assign rd_data   = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail] <= push_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (push)
        begin
            count_reg <= count_reg + 1'b1;
        end
        else if (pop)
        begin
            head_reg  <= head_next;
            count_reg <= count_reg - 1'b1;
        end
    end

endmodule

/* design/tcpsd_srv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpsd_srv
// server state table: remaining and busy totals in a synchronous memory
// ----------------------------------------------------------------------------
module tcpsd_srv #(
    parameter int NS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  rd_en,
    input  logic [((NS > 1) ? $clog2(NS) : 1)-1:0] rd_idx,
    output tcpsd_pkg::srv_entry_t                 rd_entry,
    input  logic                                  wr_en,
    input  logic [((NS > 1) ? $clog2(NS) : 1)-1:0] wr_idx,
    input  tcpsd_pkg::srv_entry_t                 wr_entry
);
    import tcpsd_pkg::*;

    srv_entry_t        mem [NS];
    srv_entry_t        rd_data_reg;
    logic              rd_vld_reg;
    logic [NS-1:0]     vld_reg;

    // entries never written read as zero
    assign rd_entry = rd_vld_reg ? rd_data_reg : '0;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_idx];
            end
        end
    end

endmodule

/* design/two_class_priority_server_dispatch.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_priority_server_dispatch
// strict-priority two-queue dispatcher over a set of servers, one tick a word
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  item      item_valid / item_stall   landing_arrivals, takeoff_arrivals,
//                                      arrivals_ended
//  result    result_valid/result_stall event_kind ... last, one word per event
//  config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
//  one tick runs from its accepting cycle through one enqueue step per arrival
//  taken in (dropped ones included) and a closing enqueue step, two passes over
//  the server table memory (a read step and an examine step per server in use,
//  and a closing step each) and the tick-end step, plus any wait of a result
//  word on result_stall
//  item_stall is high from acceptance until the tick-end word is registered
//  reset empties both queues and marks every server entry as zero; no
//  clearing pass is needed
//  a stalled result word holds in the output register until taken
// ----------------------------------------------------------------------------
module two_class_priority_server_dispatch #(
    parameter int MAX_SERVERS = 8,
    parameter int QUEUE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [3:0]  landing_arrivals,
    input  logic [3:0]  takeoff_arrivals,
    input  logic        arrivals_ended,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  event_kind,
    output logic [15:0] job_id,
    output logic [3:0]  server_number,
    output logic [15:0] tick_value,
    output logic [15:0] server_busy_total,
    output logic [31:0] landing_wait_sum,
    output logic [31:0] takeoff_wait_sum,
    output logic        queue_overflow,
    output logic        sim_done,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import tcpsd_pkg::*;

    localparam int SW  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int NW  = SW + 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ENQ  = 3'd1;
    localparam logic [2:0] S_ARD  = 3'd2;
    localparam logic [2:0] S_AEX  = 3'd3;
    localparam logic [2:0] S_CRD  = 3'd4;
    localparam logic [2:0] S_CEX  = 3'd5;
    localparam logic [2:0] S_END  = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [3:0]        srv_count_reg;
    logic [7:0]        land_time_reg, take_time_reg;
    logic [3:0]        la_left_reg, la_left_next;
    logic [3:0]        ta_left_reg, ta_left_next;
    logic              ended_reg, ended_next;
    logic              ovf_reg, ovf_next;
    logic              all_free_reg, all_free_next;
    logic [NW-1:0]     idx_reg, idx_next;
    logic [15:0]       tick_reg, tick_next;
    logic [15:0]       land_id_reg, land_id_next;
    logic [15:0]       take_id_reg, take_id_next;
    logic [31:0]       land_wait_reg, land_wait_next;
    logic [31:0]       take_wait_reg, take_wait_next;
    logic [NW-1:0]     n_eff;
    logic              out_free;
    logic              emit;

    // output word register
    logic              rv_reg;
    logic [1:0]        kind_reg, kind_next;
    logic [15:0]       job_reg, job_next;
    logic [3:0]        snum_reg, snum_next;
    logic [15:0]       busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              last_reg, last_next;

    // queue and table ports
    logic              lq_push, lq_pop, tq_push, tq_pop, q_rd;
    logic [15:0]       lq_data, tq_data;
    logic [QCW-1:0]    lq_count, tq_count;
    logic              lq_full, tq_full;
    logic              srv_rd, srv_wr;
    srv_entry_t        srv_rd_entry, srv_wr_entry;
    logic [7:0]        rem_dec;

    tcpsd_queue #(.DEPTH(QUEUE_DEPTH)) u_lq (
        .clk(clk), .rst_n(rst_n), .push(lq_push), .push_data(tick_reg), .pop(lq_pop),
        .rd_en(q_rd), .rd_data(lq_data), .count(lq_count), .full(lq_full)
    );

    tcpsd_queue #(.DEPTH(QUEUE_DEPTH)) u_tq (
        .clk(clk), .rst_n(rst_n), .push(tq_push), .push_data(tick_reg), .pop(tq_pop),
        .rd_en(q_rd), .rd_data(tq_data), .count(tq_count), .full(tq_full)
    );

    tcpsd_srv #(.NS(MAX_SERVERS)) u_srv (
        .clk(clk), .rst_n(rst_n),
        .rd_en(srv_rd), .rd_idx(idx_reg[SW-1:0]), .rd_entry(srv_rd_entry),
        .wr_en(srv_wr), .wr_idx(idx_reg[SW-1:0]), .wr_entry(srv_wr_entry)
    );

    // count above the build limit saturates
    assign n_eff = (32'(srv_count_reg) > MAX_SERVERS) ? NW'(MAX_SERVERS)
                                                      : NW'(srv_count_reg);
    assign out_free   = !rv_reg || !result_stall;
    assign item_stall = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;
    assign rem_dec    = srv_rd_entry.remaining - 8'd1;

    always_comb
    begin
        state_next     = state_reg;
        la_left_next   = la_left_reg;
        ta_left_next   = ta_left_reg;
        ended_next     = ended_reg;
        ovf_next       = ovf_reg;
        all_free_next  = all_free_reg;
        idx_next       = idx_reg;
        tick_next      = tick_reg;
        land_id_next   = land_id_reg;
        take_id_next   = take_id_reg;
        land_wait_next = land_wait_reg;
        take_wait_next = take_wait_reg;
        kind_next      = kind_reg;
        job_next       = job_reg;
        snum_next      = snum_reg;
        busy_next      = busy_reg;
        done_next      = 1'b0;
        last_next      = 1'b0;
        emit           = 1'b0;
        lq_push        = 1'b0;
        tq_push        = 1'b0;
        lq_pop         = 1'b0;
        tq_pop         = 1'b0;
        q_rd           = 1'b0;
        srv_rd         = 1'b0;
        srv_wr         = 1'b0;
        srv_wr_entry   = srv_rd_entry;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    ended_next    = ended_reg | arrivals_ended;
                    la_left_next  = ended_next ? 4'd0 : landing_arrivals;
                    ta_left_next  = ended_next ? 4'd0 : takeoff_arrivals;
                    ovf_next      = 1'b0;
                    all_free_next = 1'b1;
                    state_next    = S_ENQ;
                end
            end
            S_ENQ:
            begin
                // one arrival a cycle, landings first
                if (la_left_reg != 4'd0)
                begin
                    la_left_next = la_left_reg - 4'd1;
                    if (lq_full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        lq_push      = 1'b1;
                        land_id_next = land_id_reg + 16'd1;
                    end
                end
                else if (ta_left_reg != 4'd0)
                begin
                    ta_left_next = ta_left_reg - 4'd1;
                    if (tq_full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        tq_push      = 1'b1;
                        take_id_next = take_id_reg + 16'd1;
                    end
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_ARD;
                end
            end
            S_ARD:
            begin
                if (idx_reg == n_eff)
                begin
                    idx_next   = '0;
                    state_next = S_CRD;
                end
                else
                begin
                    srv_rd     = 1'b1;
                    q_rd       = 1'b1;
                    state_next = S_AEX;
                end
            end
            S_AEX:
            begin
                if (srv_rd_entry.remaining != 8'd0 ||
                    (lq_count == '0 && tq_count == '0))
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_ARD;
                end
                else if (out_free)
                begin
                    emit      = 1'b1;
                    srv_wr    = 1'b1;
                    snum_next = 4'(idx_reg + 1'b1);
                    if (lq_count != '0)
                    begin
                        lq_pop                 = 1'b1;
                        srv_wr_entry.remaining = land_time_reg;
                        srv_wr_entry.busy      = srv_rd_entry.busy + 16'(land_time_reg);
                        land_wait_next         = land_wait_reg + 32'(16'(tick_reg - lq_data));
                        kind_next              = EV_LANDING;
                        job_next               = land_id_reg - 16'(lq_count);
                    end
                    else
                    begin
                        tq_pop                 = 1'b1;
                        srv_wr_entry.remaining = take_time_reg;
                        srv_wr_entry.busy      = srv_rd_entry.busy + 16'(take_time_reg);
                        take_wait_next         = take_wait_reg + 32'(16'(tick_reg - tq_data));
                        kind_next              = EV_TAKEOFF;
                        job_next               = take_id_reg - 16'(tq_count);
                    end
                    busy_next  = srv_wr_entry.busy;
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_ARD;
                end
            end
            S_CRD:
            begin
                if (idx_reg == n_eff)
                begin
                    state_next = S_END;
                end
                else
                begin
                    srv_rd     = 1'b1;
                    state_next = S_CEX;
                end
            end
            S_CEX:
            begin
                srv_wr_entry.remaining = rem_dec;
                if (srv_rd_entry.remaining == 8'd0)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_CRD;
                end
                else if (rem_dec != 8'd0)
                begin
                    srv_wr        = 1'b1;
                    all_free_next = 1'b0;
                    idx_next      = idx_reg + 1'b1;
                    state_next    = S_CRD;
                end
                else if (out_free)
                begin
                    srv_wr     = 1'b1;
                    emit       = 1'b1;
                    kind_next  = EV_FREED;
                    job_next   = '0;
                    snum_next  = 4'(idx_reg + 1'b1);
                    busy_next  = srv_rd_entry.busy;
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_CRD;
                end
            end
            S_END:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    kind_next  = EV_TICK;
                    job_next   = '0;
                    snum_next  = '0;
                    busy_next  = '0;
                    done_next  = ended_reg && lq_count == '0 && tq_count == '0 && all_free_reg;
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            srv_count_reg <= 4'd1;
            land_time_reg <= 8'd1;
            take_time_reg <= 8'd1;
            la_left_reg   <= '0;
            ta_left_reg   <= '0;
            ended_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            all_free_reg  <= 1'b1;
            idx_reg       <= '0;
            tick_reg      <= TICK_FIRST;
            land_id_reg   <= LANDING_ID_FIRST;
            take_id_reg   <= TAKEOFF_ID_FIRST;
            land_wait_reg <= '0;
            take_wait_reg <= '0;
            rv_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            la_left_reg   <= la_left_next;
            ta_left_reg   <= ta_left_next;
            ended_reg     <= ended_next;
            ovf_reg       <= ovf_next;
            all_free_reg  <= all_free_next;
            idx_reg       <= idx_next;
            land_id_reg   <= land_id_next;
            take_id_reg   <= take_id_next;
            land_wait_reg <= land_wait_next;
            take_wait_reg <= take_wait_next;
            // tick advances once the tick-end word is registered
            tick_reg      <= (emit && last_next) ? tick_reg + 16'd1 : tick_next;
            if (emit)
            begin
                rv_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                rv_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SERVER_COUNT: srv_count_reg <= cfg_data[3:0];
                    CFG_LANDING_TIME: land_time_reg <= cfg_data;
                    CFG_TAKEOFF_TIME: take_time_reg <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    // output word payload
    logic [15:0] otick_reg;
    logic [31:0] olw_reg, otw_reg;
    logic        oovf_reg;

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg  <= kind_next;
            job_reg   <= job_next;
            snum_reg  <= snum_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            last_reg  <= last_next;
            otick_reg <= tick_reg;
            olw_reg   <= land_wait_next;
            otw_reg   <= take_wait_next;
            oovf_reg  <= ovf_reg;
        end
    end

    assign result_valid      = rv_reg;
    assign event_kind        = kind_reg;
    assign job_id            = job_reg;
    assign server_number     = snum_reg;
    assign tick_value        = otick_reg;
    assign server_busy_total = busy_reg;
    assign landing_wait_sum  = olw_reg;
    assign takeoff_wait_sum  = otw_reg;
    assign queue_overflow    = oovf_reg;
    assign sim_done          = done_reg;
    assign last              = last_reg;

    a_lq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(lq_count) <= QUEUE_DEPTH)
        else $error("landing queue count beyond depth");

    a_tq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(tq_count) <= QUEUE_DEPTH)
        else $error("takeoff queue count beyond depth");

    a_item_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> (state_reg == S_ENQ))
        else $error("accepted tick did not start enqueue");

    a_tick_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_END && out_free) |=> (rv_reg && last_reg && state_reg == S_IDLE))
        else $error("tick end word not registered");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rv_reg && done_reg) |-> last_reg)
        else $error("done flag outside tick end");

endmodule
